// ----- rtl/nec_ir_pulse_decoder_unit_assert.svh -----
// Assertion macros for the NEC IR pulse decoder checker.
// No dependencies; included by files that assert.
`ifndef NEC_IR_PULSE_DECODER_UNIT_ASSERT_SVH
`define NEC_IR_PULSE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NECIR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NECIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/necir_pkg.sv -----
// Shared types and constants for the NEC IR pulse decoder.
// No dependencies.
package necir_pkg;

    // Event codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RISE    = 2'd1,
        OP_FALL    = 2'd2,
        OP_SCAN    = 2'd3
    } op_t;

    // Scan modes
    localparam logic [1:0] MODE_ADDR_CHECK = 2'd0;
    localparam logic [1:0] MODE_INV_ADDR   = 2'd1;

    // Register indexes
    localparam logic REG_REMOTE_ADDRESS = 1'b0;
    localparam logic REG_SCAN_MODE      = 1'b1;

    // Leader timeout in overflow ticks
    localparam logic [3:0] TIMEOUT_TICKS = 4'd14;

    // Pulse windows in microseconds (open intervals)
    localparam logic [15:0] ZERO_LO   = 16'd450;
    localparam logic [15:0] ZERO_HI   = 16'd700;
    localparam logic [15:0] ONE_LO    = 16'd1400;
    localparam logic [15:0] ONE_HI    = 16'd1800;
    localparam logic [15:0] REPEAT_LO = 16'd2200;
    localparam logic [15:0] REPEAT_HI = 16'd2600;
    localparam logic [15:0] LEADER_LO = 16'd4200;
    localparam logic [15:0] LEADER_HI = 16'd4700;

    typedef struct packed {
        op_t         operation;
        logic [15:0] high_time_us;
    } in_item_t;

    typedef struct packed {
        logic [31:0] key_value;
        logic        key_valid;
        logic        frame_ready;
        logic        leader_active;
        logic [7:0]  repeat_total;
        logic [31:0] frame_bits;
    } out_item_t;

    // Configuration handed from the register block to the core
    typedef struct packed {
        logic [7:0] remote_address;
        logic [1:0] scan_mode;
    } cfg_t;

endpackage

// ----- rtl/nec_ir_pulse_decoder_unit.sv -----
// Top level of the NEC IR pulse decoder: APB registers and decoder core.
// Depends on necir_pkg, necir_regs, necir_core.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------
//  input    | s_valid / s_ready  | s_data (in_item_t)
//  result   | m_valid / m_ready  | m_data (out_item_t)
//  config   | psel/penable/pwrite| paddr, pwdata, prdata
//
// Each event passes through the input register and then the result register;
// one event per cycle is sustained while m_ready stays high.
// The frame state updates in one pass of compares and a shift per event.
// A stall on m_ready holds the result; s_ready drops in the same cycle once
// the input register holds an event.
// Synchronous active-low reset clears the frame state, the valid flags and the config registers.
module nec_ir_pulse_decoder_unit
    import necir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;

    necir_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    necir_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/necir_regs.sv -----
// APB configuration registers: remote address and scan mode.
// Depends on necir_pkg.
module necir_regs
    import necir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] remote_address_reg;
    logic [1:0] scan_mode_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remote_address_reg <= 8'd0;
            scan_mode_reg      <= 2'd0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_REMOTE_ADDRESS: remote_address_reg <= pwdata[7:0];
                REG_SCAN_MODE:      scan_mode_reg      <= pwdata[1:0];
                default:            ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_sel)
            REG_REMOTE_ADDRESS: prdata = {24'd0, remote_address_reg};
            REG_SCAN_MODE:      prdata = {30'd0, scan_mode_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.remote_address = remote_address_reg;
    assign cfg.scan_mode      = scan_mode_reg;

endmodule

// ----- rtl/necir_core.sv -----
// Decoder core: input register, frame state update and result register.
// Depends on necir_pkg.
module necir_core
    import necir_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        advance;

    logic        leader_reg, leader_next;
    logic        done_reg, done_next;
    logic        rise_reg, rise_next;
    logic [3:0]  tick_reg, tick_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  repeat_reg, repeat_next;
    logic [31:0] key;

    logic [15:0] t;
    logic [7:0]  f_addr, f_naddr, f_key, f_nkey;
    logic        key_ok, addr_ok;
    logic [31:0] scan_result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Field split of the current frame
    assign t       = in_item_reg.high_time_us;
    assign f_addr  = shift_reg[31:24];
    assign f_naddr = shift_reg[23:16];
    assign f_key   = shift_reg[15:8];
    assign f_nkey  = shift_reg[7:0];
    assign key_ok  = (f_key == ~f_nkey);
    assign addr_ok = (f_addr == ~f_naddr) && (f_addr == cfg.remote_address);

    // Key per scan mode
    always_comb begin
        scan_result = 32'd0;
        case (cfg.scan_mode)
            MODE_ADDR_CHECK: if (addr_ok && key_ok) scan_result = {24'd0, f_key};
            MODE_INV_ADDR:   if (key_ok) scan_result = {16'd0, f_naddr, f_key};
            default:         if (key_ok && (f_key != 8'd0)) scan_result = shift_reg;
        endcase
    end

    // Next state for the held item
    always_comb begin
        leader_next = leader_reg;
        done_next   = done_reg;
        rise_next   = rise_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;
        repeat_next = repeat_reg;
        key         = 32'd0;
        case (in_item_reg.operation)
            OP_TICK: begin
                if (leader_reg) begin
                    rise_next = 1'b0;
                    if (tick_reg == 4'd0) done_next = 1'b1;
                    if (tick_reg < TIMEOUT_TICKS) begin
                        tick_next = tick_reg + 4'd1;
                    end else begin
                        leader_next = 1'b0;
                        tick_next   = 4'd0;
                    end
                end
            end
            OP_RISE: rise_next = 1'b1;
            OP_FALL: begin
                rise_next = 1'b0;
                if (rise_reg) begin
                    if (leader_reg) begin
                        if (t > ZERO_LO && t < ZERO_HI) begin
                            shift_next = {shift_reg[30:0], 1'b0};
                        end else if (t > ONE_LO && t < ONE_HI) begin
                            shift_next = {shift_reg[30:0], 1'b1};
                        end else if (t > REPEAT_LO && t < REPEAT_HI) begin
                            repeat_next = repeat_reg + 8'd1;
                            tick_next   = 4'd0;
                        end
                    end else if (t > LEADER_LO && t < LEADER_HI) begin
                        leader_next = 1'b1;
                        repeat_next = 8'd0;
                    end
                end
            end
            OP_SCAN: begin
                if (done_reg) begin
                    key = scan_result;
                    if ((scan_result == 32'd0) || !leader_reg) begin
                        done_next   = 1'b0;
                        repeat_next = 8'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Input register, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            leader_reg    <= 1'b0;
            done_reg      <= 1'b0;
            rise_reg      <= 1'b0;
            tick_reg      <= 4'd0;
            shift_reg     <= 32'd0;
            repeat_reg    <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
                if (s_valid) in_item_reg <= s_data;
            end
            if (advance) begin
                leader_reg                 <= leader_next;
                done_reg                   <= done_next;
                rise_reg                   <= rise_next;
                tick_reg                   <= tick_next;
                shift_reg                  <= shift_next;
                repeat_reg                 <= repeat_next;
                out_valid_reg              <= 1'b1;
                out_item_reg.key_value     <= key;
                out_item_reg.key_valid     <= (key != 32'd0);
                out_item_reg.frame_ready   <= done_next;
                out_item_reg.leader_active <= leader_next;
                out_item_reg.repeat_total  <= repeat_next;
                out_item_reg.frame_bits    <= shift_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// ----- rtl/necir_checker.sv -----
// Port-level checks for the NEC IR pulse decoder, bound to the top level.
// Depends on necir_pkg and nec_ir_pulse_decoder_unit_assert.svh.
`include "nec_ir_pulse_decoder_unit_assert.svh"

module necir_checker
    import necir_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic out_stall;
    logic key_nz;
    logic frame_nz;
    logic live_key;

    assign out_stall = m_valid && !m_ready;
    assign key_nz    = (m_data.key_value != 32'd0);
    assign frame_nz  = (m_data.frame_bits != 32'd0);
    assign live_key  = m_valid && m_data.key_valid && m_data.leader_active;

    // A stalled result holds its payload
    `NECIR_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_data), "stalled result changed")

    // The input only stalls behind a stalled result
    `NECIR_ASSERT_IMPL(a_in_stall, !s_ready, out_stall, "input stalled without a result stall")

    // key_valid tracks a nonzero key
    `NECIR_ASSERT_IMPL(a_key_flag, m_valid, m_data.key_valid == key_nz, "key_valid mismatch")

    // A good key with the leader present keeps the frame marked done
    `NECIR_ASSERT_IMPL(a_key_done, live_key, m_data.frame_ready, "frame_ready dropped on good key")

    // A passing key check implies a nonzero frame
    `NECIR_ASSERT_IMPL(a_key_frame, m_valid && m_data.key_valid, frame_nz, "key from empty frame")

endmodule

bind nec_ir_pulse_decoder_unit necir_checker u_necir_checker (.*);

// ----- verif/nec_ir_pulse_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for nec_ir_pulse_decoder_unit: NEC frames, repeats and noise
// are pushed through the event channel while a built-in decoder predicts each untyped report.
// Depends on necir_pkg and the RTL of the unit only.
module nec_ir_pulse_decoder_unit_tb;
    import necir_pkg::*;

    // Scan modes that the package leaves unnamed (3 aliases the whole-frame mode)
    localparam logic [1:0] MODE_FRAME       = 2'd2;
    localparam logic [1:0] MODE_FRAME_ALIAS = 2'd3;

    // Register byte addresses
    localparam logic [2:0] ADDR_REMOTE = {REG_REMOTE_ADDRESS, 2'b00};
    localparam logic [2:0] ADDR_MODE   = {REG_SCAN_MODE, 2'b00};

    localparam out_item_t ZERO_OUT = '0;
    localparam int HOLD_CYCLES     = 50;
    localparam int PHASE_EVENTS    = 130;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nec_ir_pulse_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decoder shadow state and register copies (all clear out of reset)
    logic        sh_leader   = 1'b0;
    logic        sh_done     = 1'b0;
    logic        sh_rise     = 1'b0;
    logic [3:0]  sh_ticks    = '0;
    logic [31:0] sh_frame    = '0;
    logic [7:0]  sh_repeats  = '0;
    logic [7:0]  cfg_address = '0;
    logic [1:0]  cfg_mode    = MODE_ADDR_CHECK;

    out_item_t decoder_reports_q[$];

    int  n_events   = 0;
    int  n_results  = 0;
    int  n_keys     = 0;
    int  n_errors   = 0;
    int  gap_odds   = 3;
    int  stall_odds = 3;
    bit  steady     = 1'b0;
    bit  hold_req   = 1'b0;

    // Directed rows: reset-time cases carry a typed report, the rest use the predictor
    typedef struct {
        op_t         op;
        logic [15:0] t;
        bit          typed;
        out_item_t   want;
    } dir_row_t;

    dir_row_t dir_rows [25] = '{
        '{OP_TICK, 16'd0,     1'b1, ZERO_OUT},  // tick with no leader
        '{OP_SCAN, 16'hFFFF,  1'b1, ZERO_OUT},  // scan with no frame done
        '{OP_FALL, 16'd4500,  1'b1, ZERO_OUT},  // fall with no rise before it
        '{OP_RISE, 16'hFFFF,  1'b1, ZERO_OUT},
        '{OP_FALL, 16'd4700,  1'b1, ZERO_OUT},  // leader window is open at the top
        '{OP_RISE, 16'd0,     1'b1, ZERO_OUT},
        '{OP_FALL, 16'd4200,  1'b1, ZERO_OUT},  // ... and at the bottom
        '{OP_RISE, 16'd0,     1'b0, ZERO_OUT},
        '{OP_FALL, 16'd4201,  1'b0, ZERO_OUT},  // leader
        '{OP_RISE, 16'd1,     1'b0, ZERO_OUT},
        '{OP_FALL, 16'd450,   1'b0, ZERO_OUT},  // just outside the zero window
        '{OP_RISE, 16'd2,     1'b0, ZERO_OUT},
        '{OP_FALL, 16'd451,   1'b0, ZERO_OUT},  // zero bit
        '{OP_RISE, 16'd4,     1'b0, ZERO_OUT},
        '{OP_FALL, 16'd1799,  1'b0, ZERO_OUT},  // one bit
        '{OP_RISE, 16'd8,     1'b0, ZERO_OUT},
        '{OP_FALL, 16'd700,   1'b0, ZERO_OUT},  // ignored
        '{OP_RISE, 16'd16,    1'b0, ZERO_OUT},
        '{OP_FALL, 16'd2599,  1'b0, ZERO_OUT},  // repeat code
        '{OP_TICK, 16'h8000,  1'b0, ZERO_OUT},  // first tick marks the frame done
        '{OP_SCAN, 16'h7FFF,  1'b0, ZERO_OUT},  // failed address check
        '{OP_RISE, 16'h5555,  1'b0, ZERO_OUT},
        '{OP_FALL, 16'd1400,  1'b0, ZERO_OUT},  // one window is open too
        '{OP_RISE, 16'hAAAA,  1'b0, ZERO_OUT},
        '{OP_FALL, 16'hFFFF,  1'b0, ZERO_OUT}   // out of every window
    };

    // Predict the report for one accepted event and advance the shadow state
    function automatic out_item_t decode_event(in_item_t ev);
        out_item_t   rep;
        logic [7:0]  adr;
        logic [7:0]  nadr;
        logic [7:0]  key;
        logic [7:0]  nkey;
        logic [31:0] scan_key;
        logic        key_ok;
        adr      = sh_frame[31:24];
        nadr     = sh_frame[23:16];
        key      = sh_frame[15:8];
        nkey     = sh_frame[7:0];
        key_ok   = (key == ~nkey);
        scan_key = '0;
        case (ev.operation)
            OP_TICK: begin
                if (sh_leader) begin
                    sh_rise = 1'b0;
                    if (sh_ticks == 4'd0) sh_done = 1'b1;
                    if (sh_ticks < TIMEOUT_TICKS) begin
                        sh_ticks = sh_ticks + 4'd1;
                    end else begin
                        sh_leader = 1'b0;
                        sh_ticks  = '0;
                    end
                end
            end
            OP_RISE: sh_rise = 1'b1;
            OP_FALL: begin
                if (sh_rise) begin
                    if (sh_leader) begin
                        if (ev.high_time_us > ZERO_LO && ev.high_time_us < ZERO_HI) begin
                            sh_frame = {sh_frame[30:0], 1'b0};
                        end else if (ev.high_time_us > ONE_LO && ev.high_time_us < ONE_HI) begin
                            sh_frame = {sh_frame[30:0], 1'b1};
                        end else if (ev.high_time_us > REPEAT_LO &&
                                     ev.high_time_us < REPEAT_HI) begin
                            sh_repeats = sh_repeats + 8'd1;
                            sh_ticks   = '0;
                        end
                    end else if (ev.high_time_us > LEADER_LO && ev.high_time_us < LEADER_HI) begin
                        sh_leader  = 1'b1;
                        sh_repeats = '0;
                    end
                end
                sh_rise = 1'b0;
            end
            default: begin
                if (sh_done) begin
                    case (cfg_mode)
                        MODE_ADDR_CHECK: begin
                            if (adr == ~nadr && adr == cfg_address && key_ok)
                                scan_key = {24'd0, key};
                        end
                        MODE_INV_ADDR: begin
                            if (key_ok) scan_key = {16'd0, nadr, key};
                        end
                        default: begin
                            if (key_ok && key != 8'd0) scan_key = sh_frame;
                        end
                    endcase
                    // failed check or lost leader ends the frame
                    if (scan_key == '0 || !sh_leader) begin
                        sh_done    = 1'b0;
                        sh_repeats = '0;
                    end
                end
            end
        endcase
        rep.key_value     = scan_key;
        rep.key_valid     = (scan_key != '0);
        rep.frame_ready   = sh_done;
        rep.leader_active = sh_leader;
        rep.repeat_total  = sh_repeats;
        rep.frame_bits    = sh_frame;
        return rep;
    endfunction

    // Offer one event, hold it until the transfer, then maybe idle a burst
    task automatic push_item(in_item_t ev, bit typed, out_item_t want);
        out_item_t pred;
        s_data  <= ev;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = decode_event(ev);
        decoder_reports_q.push_back(typed ? want : pred);
        n_events++;
        if (!steady && $urandom_range(0, gap_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send(op_t op, logic [15:0] t);
        in_item_t ev;
        ev.operation    = op;
        ev.high_time_us = t;
        push_item(ev, 1'b0, ZERO_OUT);
    endtask

    // Wait for every report, then let the pipeline settle
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (decoder_reports_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup then access, register updates at the access edge
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_REMOTE) cfg_address = value[7:0];
        else cfg_mode = value[1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One NEC frame: leader, 32 bits, ticks, scans, repeats, and usually a timeout
    task automatic send_frame();
        logic [7:0]  adr;
        logic [7:0]  key;
        logic [31:0] word;
        logic [15:0] t;
        adr  = ($urandom_range(0, 3) != 0) ? cfg_address : 8'($urandom);
        key  = 8'($urandom);
        word = {adr, ~adr, key, ~key};
        if ($urandom_range(0, 5) == 0) word = word ^ (32'd1 << $urandom_range(0, 31));
        send(OP_RISE, 16'($urandom));
        t = ($urandom_range(0, 7) != 0) ? 16'($urandom_range(LEADER_LO + 1, LEADER_HI - 1))
                                        : 16'($urandom);
        send(OP_FALL, t);
        for (int i = 31; i >= 0; i--) begin
            // an occasional lost rising edge drops a bit
            if ($urandom_range(0, 40) != 0) send(OP_RISE, 16'($urandom));
            if ($urandom_range(0, 60) == 0) t = 16'($urandom);
            else if (word[i]) t = 16'($urandom_range(ONE_LO + 1, ONE_HI - 1));
            else t = 16'($urandom_range(ZERO_LO + 1, ZERO_HI - 1));
            send(OP_FALL, t);
        end
        repeat ($urandom_range(1, 3)) send(OP_TICK, 16'($urandom));
        send(OP_SCAN, 16'($urandom));
        repeat ($urandom_range(0, 3)) begin
            send(OP_RISE, 16'($urandom));
            send(OP_FALL, 16'($urandom_range(REPEAT_LO + 1, REPEAT_HI - 1)));
            send(OP_TICK, 16'($urandom));
            send(OP_SCAN, 16'($urandom));
        end
        if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(15, 17)) send(OP_TICK, 16'($urandom));
            send(OP_SCAN, 16'($urandom));
        end
    endtask

    // Long run of repeat codes so the repeat counter wraps
    task automatic send_repeat_wrap();
        repeat (16) send(OP_TICK, 16'($urandom));
        send(OP_RISE, 16'($urandom));
        send(OP_FALL, 16'd4500);
        repeat (258) begin
            send(OP_RISE, 16'($urandom));
            send(OP_FALL, 16'($urandom_range(REPEAT_LO + 1, REPEAT_HI - 1)));
        end
        send(OP_TICK, 16'($urandom));
        send(OP_SCAN, 16'($urandom));
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (aresetn && !steady && $urandom_range(0, stall_odds) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest predicted report
    always @(posedge aclk) begin : check_reports
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoder_reports_q.size() == 0) begin
                $error("result transfer with no event pending: %h", m_data);
                n_errors++;
            end else begin
                want = decoder_reports_q.pop_front();
                n_results++;
                if (want.key_valid) n_keys++;
                if (m_data.key_value !== want.key_value) begin
                    $error("key_value expected %h got %h", want.key_value, m_data.key_value);
                    n_errors++;
                end
                if (m_data.key_valid !== want.key_valid) begin
                    $error("key_valid expected %b got %b", want.key_valid, m_data.key_valid);
                    n_errors++;
                end
                if (m_data.frame_ready !== want.frame_ready) begin
                    $error("frame_ready expected %b got %b", want.frame_ready,
                           m_data.frame_ready);
                    n_errors++;
                end
                if (m_data.leader_active !== want.leader_active) begin
                    $error("leader_active expected %b got %b", want.leader_active,
                           m_data.leader_active);
                    n_errors++;
                end
                if (m_data.repeat_total !== want.repeat_total) begin
                    $error("repeat_total expected %0d got %0d", want.repeat_total,
                           m_data.repeat_total);
                    n_errors++;
                end
                if (m_data.frame_bits !== want.frame_bits) begin
                    $error("frame_bits expected %h got %h", want.frame_bits, m_data.frame_bits);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus: reset, directed rows, then eight register settings of random traffic
    initial begin
        logic [7:0]  phase_addr;
        logic [1:0]  phase_mode;
        logic [1:0]  code;
        int          start;
        int          pick;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (dir_rows[i])
            push_item('{dir_rows[i].op, dir_rows[i].t}, dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < 8; p++) begin
            drain_reports();
            case (p)
                0: begin phase_addr = 8'hA5; phase_mode = MODE_ADDR_CHECK;  end
                1: begin phase_addr = 8'h00; phase_mode = MODE_INV_ADDR;    end
                2: begin phase_addr = 8'hFF; phase_mode = MODE_FRAME;       end
                3: begin phase_addr = 8'h3C; phase_mode = MODE_FRAME_ALIAS; end
                4: begin phase_addr = 8'h00; phase_mode = MODE_ADDR_CHECK;  end
                5: begin phase_addr = 8'hFF; phase_mode = MODE_ADDR_CHECK;  end
                6: begin phase_addr = 8'($urandom); phase_mode = MODE_INV_ADDR; end
                default: begin phase_addr = 8'($urandom); phase_mode = MODE_FRAME; end
            endcase
            // upper data bits are don't-care
            apb_write(ADDR_REMOTE, ($urandom & ~32'hFF) | {24'd0, phase_addr});
            apb_write(ADDR_MODE, ($urandom & ~32'h3) | {30'd0, phase_mode});
            @(posedge aclk);
            gap_odds   = (p % 2 == 0) ? 3 : 11;
            stall_odds = (p % 2 == 0) ? 11 : 3;
            steady     = (p == 7);
            if (p == 2) hold_req = 1'b1;
            if (p == 4) send_repeat_wrap();
            start = n_events;
            while (n_events - start < PHASE_EVENTS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    send_frame();
                end else if (pick < 8) begin
                    send(OP_RISE, 16'($urandom));
                    send(OP_FALL, 16'($urandom_range(REPEAT_LO + 1, REPEAT_HI - 1)));
                    send(OP_TICK, 16'($urandom));
                    send(OP_SCAN, 16'($urandom));
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        code = 2'($urandom_range(0, 3));
                        send(op_t'(code), 16'($urandom));
                    end
                end
            end
        end

        drain_reports();
        repeat (8) @(posedge aclk);
        $display("%0d events, %0d reports checked, %0d valid keys, 8 register settings",
                 n_events, n_results, n_keys);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("watchdog expired with %0d reports outstanding", decoder_reports_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
